FILE: hdl/sal_pkg.sv
// Shared types, command codes and controller/datapath interface structs for
// the sequential array list. Depends on nothing; every other file uses it.

package sal_pkg;

  // Default sizes handed to the top level's parameters.
  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // Command codes carried in the request's cmd field.
  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_DELETE = 3'd1;
  localparam logic [2:0] CMD_APPEND = 3'd2;
  localparam logic [2:0] CMD_SET    = 3'd3;
  localparam logic [2:0] CMD_GET    = 3'd4;
  localparam logic [2:0] CMD_FIND   = 3'd5;

  // Pointer operations.
  localparam logic [2:0] PTR_HOLD   = 3'd0;
  localparam logic [2:0] PTR_CNT_M1 = 3'd1;
  localparam logic [2:0] PTR_POS    = 3'd2;
  localparam logic [2:0] PTR_ZERO   = 3'd3;
  localparam logic [2:0] PTR_INC    = 3'd4;
  localparam logic [2:0] PTR_DEC    = 3'd5;

  // Memory address selections.
  localparam logic [1:0] ADDR_PTR    = 2'd0;
  localparam logic [1:0] ADDR_PTR_P1 = 2'd1;
  localparam logic [1:0] ADDR_POS    = 2'd2;
  localparam logic [1:0] ADDR_COUNT  = 2'd3;

  // Entry count operations.
  localparam logic [1:0] CNT_HOLD = 2'd0;
  localparam logic [1:0] CNT_INC  = 2'd1;
  localparam logic [1:0] CNT_DEC  = 2'd2;

  // What the response carries besides the flags.
  localparam logic [1:0] RSP_PLAIN = 2'd0;
  localparam logic [1:0] RSP_READ  = 2'd1;
  localparam logic [1:0] RSP_FOUND = 2'd2;

  // Request transaction.
  typedef struct packed {
    logic [2:0]  cmd;
    logic [4:0]  slot;
    logic [31:0] data_in;
  } req_t;

  // Response transaction.
  typedef struct packed {
    logic        ok;
    logic [31:0] data_out;
    logic [3:0]  found_slot;
    logic [4:0]  length;
    logic        empty_res;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       latch;
    logic [2:0] ptr_op;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       wr_en;
    logic [1:0] wa_sel;
    logic       wd_rdata;
    logic [1:0] cnt_op;
    logic       resp_en;
    logic       resp_ok;
    logic [1:0] resp_kind;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] op;
    logic       ins_legal;
    logic       in_range;
    logic       has_room;
    logic       pos_at_end;
    logic       del_tail;
    logic       ptr_at_pos;
    logic       ptr_end_del;
    logic       ptr_last;
    logic       match;
    logic       count_zero;
  } stat_t;

endpackage

FILE: hdl/sal_dp.sv
// Datapath of the sequential array list: entry memory, entry count, walk
// pointer, latched request and response register. Uses sal_pkg.

module sal_dp #(
  parameter int DEPTH      = sal_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = sal_pkg::DATA_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  sal_pkg::ctl_t ctl,
  input  sal_pkg::req_t request,
  output sal_pkg::stat_t stat,
  output sal_pkg::rsp_t response,
  output logic          done
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CW5  = (CW > 5) ? CW : 5;
  localparam int CMPW = CW5 + 1;
  localparam int DMAX = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata;
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  logic [AW-1:0]         ptr;
  logic [AW-1:0]         ptr_next;
  logic [2:0]            op;
  logic [4:0]            pos;
  logic [DATA_WIDTH-1:0] val;

  logic [CMPW-1:0]       count_w;
  logic [CMPW-1:0]       count_next_w;
  logic [CMPW-1:0]       pos_w;
  logic [CMPW-1:0]       ptr_w;
  logic [CW-1:0]         count_m1;
  logic [AW-1:0]         ptr_p1;
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [DMAX-1:0]       in_ext;
  logic [DMAX-1:0]       rd_ext;
  logic [DATA_WIDTH-1:0] in_val;

  // Common-width views for the range checks.
  assign count_w      = {{(CMPW - CW){1'b0}}, count};
  assign count_next_w = {{(CMPW - CW){1'b0}}, count_next};
  assign pos_w        = {{(CMPW - 5){1'b0}}, pos};
  assign ptr_w        = {{(CMPW - AW){1'b0}}, ptr};
  assign count_m1     = count - CW'(1);
  assign ptr_p1       = ptr + AW'(1);

  // Fit the request value to the storage width and the stored word to the port.
  always_comb begin
    in_ext                   = '0;
    in_ext[31:0]             = request.data_in;
    in_val                   = in_ext[DATA_WIDTH-1:0];
    rd_ext                   = '0;
    rd_ext[DATA_WIDTH-1:0]   = rdata;
  end

  // Latch the request when the transaction is accepted.
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      op  <= request.cmd;
      pos <= request.slot;
      val <= in_val;
    end
  end

  // Status for the controller.
  always_comb begin
    stat.op          = op;
    stat.has_room    = count < DEPTH_C;
    stat.ins_legal   = (count < DEPTH_C) && (pos_w <= count_w);
    stat.in_range    = pos_w < count_w;
    stat.pos_at_end  = pos_w == count_w;
    stat.del_tail    = (pos_w + CMPW'(1)) == count_w;
    stat.ptr_at_pos  = ptr_w == pos_w;
    stat.ptr_end_del = (ptr_w + CMPW'(2)) == count_w;
    stat.ptr_last    = (ptr_w + CMPW'(1)) == count_w;
    stat.match       = rdata == val;
    stat.count_zero  = count == '0;
  end

  // Address and data selection for the memory ports.
  always_comb begin
    case (ctl.rd_sel)
      sal_pkg::ADDR_PTR:    rd_addr = ptr;
      sal_pkg::ADDR_PTR_P1: rd_addr = ptr_p1;
      sal_pkg::ADDR_POS:    rd_addr = pos_w[AW-1:0];
      default:              rd_addr = count_w[AW-1:0];
    endcase
    case (ctl.wa_sel)
      sal_pkg::ADDR_PTR:    wr_addr = ptr;
      sal_pkg::ADDR_PTR_P1: wr_addr = ptr_p1;
      sal_pkg::ADDR_POS:    wr_addr = pos_w[AW-1:0];
      default:              wr_addr = count_w[AW-1:0];
    endcase
    wr_data = ctl.wd_rdata ? rdata : val;
  end

  // Entry memory: one write and one registered read a cycle.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Next values of the count and the walk pointer.
  always_comb begin
    case (ctl.cnt_op)
      sal_pkg::CNT_INC: count_next = count + CW'(1);
      sal_pkg::CNT_DEC: count_next = count_m1;
      default:          count_next = count;
    endcase
    case (ctl.ptr_op)
      sal_pkg::PTR_CNT_M1: ptr_next = count_m1[AW-1:0];
      sal_pkg::PTR_POS:    ptr_next = pos_w[AW-1:0];
      sal_pkg::PTR_ZERO:   ptr_next = '0;
      sal_pkg::PTR_INC:    ptr_next = ptr_p1;
      sal_pkg::PTR_DEC:    ptr_next = ptr - AW'(1);
      default:             ptr_next = ptr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ptr   <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      ptr   <= ptr_next;
      done  <= ctl.resp_en;
    end
  end

  // Response register, loaded as the command finishes.
  always_ff @(posedge clk) begin
    if (ctl.resp_en) begin
      response.ok         <= ctl.resp_ok;
      response.data_out   <= (ctl.resp_kind == sal_pkg::RSP_READ) ? rd_ext[31:0] : 32'd0;
      response.found_slot <= (ctl.resp_kind == sal_pkg::RSP_FOUND) ? ptr_w[3:0] : 4'd0;
      response.length     <= count_next_w[4:0];
      response.empty_res  <= count_next == '0;
    end
  end

  // The count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= DEPTH_C)
    else $error("entry count beyond capacity");

  // The count only moves by one as a command completes.
  a_count_moves_on_resp: assert property (@(posedge clk) disable iff (rst)
    (ctl.cnt_op != sal_pkg::CNT_HOLD) |-> ctl.resp_en)
    else $error("entry count changed outside command completion");

endmodule

FILE: hdl/sal_ctrl.sv
// Controller of the sequential array list: decodes the latched command and
// steps the datapath through shifts and scans. Uses sal_pkg.

module sal_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  sal_pkg::stat_t stat,
  output sal_pkg::ctl_t  ctl,
  output logic           busy
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_IRD    = 4'd2;
  localparam logic [3:0] S_IWR    = 4'd3;
  localparam logic [3:0] S_IPUT   = 4'd4;
  localparam logic [3:0] S_DRD    = 4'd5;
  localparam logic [3:0] S_DWR    = 4'd6;
  localparam logic [3:0] S_GRD    = 4'd7;
  localparam logic [3:0] S_FRD    = 4'd8;
  localparam logic [3:0] S_FCMP   = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  assign busy = state != S_IDLE;

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next  = S_IDLE;
        ctl.resp_en = 1'b1;
        case (stat.op)
          sal_pkg::CMD_INSERT: begin
            if (stat.ins_legal && stat.pos_at_end) begin
              ctl.wr_en   = 1'b1;
              ctl.wa_sel  = sal_pkg::ADDR_POS;
              ctl.cnt_op  = sal_pkg::CNT_INC;
              ctl.resp_ok = 1'b1;
            end else if (stat.ins_legal) begin
              ctl.resp_en = 1'b0;
              ctl.ptr_op  = sal_pkg::PTR_CNT_M1;
              state_next  = S_IRD;
            end
          end
          sal_pkg::CMD_DELETE: begin
            if (stat.in_range && stat.del_tail) begin
              ctl.cnt_op  = sal_pkg::CNT_DEC;
              ctl.resp_ok = 1'b1;
            end else if (stat.in_range) begin
              ctl.resp_en = 1'b0;
              ctl.ptr_op  = sal_pkg::PTR_POS;
              state_next  = S_DRD;
            end
          end
          sal_pkg::CMD_APPEND: begin
            if (stat.has_room) begin
              ctl.wr_en   = 1'b1;
              ctl.wa_sel  = sal_pkg::ADDR_COUNT;
              ctl.cnt_op  = sal_pkg::CNT_INC;
              ctl.resp_ok = 1'b1;
            end
          end
          sal_pkg::CMD_SET: begin
            if (stat.in_range) begin
              ctl.wr_en   = 1'b1;
              ctl.wa_sel  = sal_pkg::ADDR_POS;
              ctl.resp_ok = 1'b1;
            end
          end
          sal_pkg::CMD_GET: begin
            if (stat.in_range) begin
              ctl.resp_en = 1'b0;
              ctl.rd_en   = 1'b1;
              ctl.rd_sel  = sal_pkg::ADDR_POS;
              state_next  = S_GRD;
            end
          end
          sal_pkg::CMD_FIND: begin
            if (!stat.count_zero) begin
              ctl.resp_en = 1'b0;
              ctl.ptr_op  = sal_pkg::PTR_ZERO;
              state_next  = S_FRD;
            end
          end
          default: begin
            ctl.resp_ok = 1'b0;
          end
        endcase
      end
      // Insert: move entries up one place, from the top down to the position.
      S_IRD: begin
        ctl.rd_en  = 1'b1;
        ctl.rd_sel = sal_pkg::ADDR_PTR;
        state_next = S_IWR;
      end
      S_IWR: begin
        ctl.wr_en    = 1'b1;
        ctl.wa_sel   = sal_pkg::ADDR_PTR_P1;
        ctl.wd_rdata = 1'b1;
        if (stat.ptr_at_pos) begin
          state_next = S_IPUT;
        end else begin
          ctl.ptr_op = sal_pkg::PTR_DEC;
          state_next = S_IRD;
        end
      end
      S_IPUT: begin
        ctl.wr_en   = 1'b1;
        ctl.wa_sel  = sal_pkg::ADDR_POS;
        ctl.cnt_op  = sal_pkg::CNT_INC;
        ctl.resp_en = 1'b1;
        ctl.resp_ok = 1'b1;
        state_next  = S_IDLE;
      end
      // Delete: move entries down one place, from the position to the top.
      S_DRD: begin
        ctl.rd_en  = 1'b1;
        ctl.rd_sel = sal_pkg::ADDR_PTR_P1;
        state_next = S_DWR;
      end
      S_DWR: begin
        ctl.wr_en    = 1'b1;
        ctl.wa_sel   = sal_pkg::ADDR_PTR;
        ctl.wd_rdata = 1'b1;
        if (stat.ptr_end_del) begin
          ctl.cnt_op  = sal_pkg::CNT_DEC;
          ctl.resp_en = 1'b1;
          ctl.resp_ok = 1'b1;
          state_next  = S_IDLE;
        end else begin
          ctl.ptr_op = sal_pkg::PTR_INC;
          state_next = S_DRD;
        end
      end
      S_GRD: begin
        ctl.resp_en   = 1'b1;
        ctl.resp_ok   = 1'b1;
        ctl.resp_kind = sal_pkg::RSP_READ;
        state_next    = S_IDLE;
      end
      // Find: read and compare one entry at a time from the bottom.
      S_FRD: begin
        ctl.rd_en  = 1'b1;
        ctl.rd_sel = sal_pkg::ADDR_PTR;
        state_next = S_FCMP;
      end
      S_FCMP: begin
        if (stat.match) begin
          ctl.resp_en   = 1'b1;
          ctl.resp_ok   = 1'b1;
          ctl.resp_kind = sal_pkg::RSP_FOUND;
          state_next    = S_IDLE;
        end else if (stat.ptr_last) begin
          ctl.resp_en = 1'b1;
          state_next  = S_IDLE;
        end else begin
          ctl.ptr_op = sal_pkg::PTR_INC;
          state_next = S_FRD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A request is only latched while idle.
  a_latch_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.latch |-> (state == S_IDLE))
    else $error("request latched while busy");

  // Every response returns the controller to idle.
  a_resp_ends: assert property (@(posedge clk) disable iff (rst)
    ctl.resp_en |=> (state == S_IDLE))
    else $error("controller still busy after response");

  // The single memory port pair is never asked to read and write at once.
  a_one_access: assert property (@(posedge clk) disable iff (rst)
    !(ctl.rd_en && ctl.wr_en))
    else $error("read and write issued in the same cycle");

endmodule

FILE: hdl/sequential_array_list.sv
// Top level of the sequential array list: joins the controller and the
// datapath. Uses sal_pkg, sal_ctrl and sal_dp.
//
// Usage: a request transaction (cmd, slot, data_in) is taken at a rising edge
// where start is high and busy is low. Exactly one response transaction
// (ok, data_out, found_slot, length, empty_res) follows, shown on response
// for one cycle while done is high; it cannot be held off.
// Entries live in a memory with one write port and one registered read port;
// shifts and scans go one entry at a time through that port pair: each entry
// is read and then written back one place over (insert, delete) or compared
// with the latched request value (find).
// busy falls in the done cycle, so the next request may be taken at the
// edge that ends it. Synchronous reset empties the list; stored words are
// not cleared, since no command reads beyond the length.

module sequential_array_list #(
  parameter int DEPTH      = sal_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = sal_pkg::DATA_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  sal_pkg::req_t request,
  output logic          done,
  output sal_pkg::rsp_t response
);

  sal_pkg::ctl_t  ctl;
  sal_pkg::stat_t stat;

  sal_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy)
  );

  sal_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .request  (request),
    .stat     (stat),
    .response (response),
    .done     (done)
  );

endmodule
